### hw/rtl/gas_alarm_controller_defines.svh
// Assertion macros for the gas alarm controller
`ifndef GAS_ALARM_CONTROLLER_DEFINES_SVH
`define GAS_ALARM_CONTROLLER_DEFINES_SVH
`ifndef SYNTH
`define GAC_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define GAC_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define GAC_ASSERT_IMP(label, clk, rst_n, a, c)
`define GAC_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

### hw/rtl/gac_pkg.sv
// ----------------------------------------------------------------------------
// gac_pkg
// Shared types and constants of the gas alarm controller.
// ----------------------------------------------------------------------------
package gac_pkg;
  localparam int ADC_BITS = 12;
  localparam int NUM_W = ADC_BITS * 2 + 10;
  localparam int DEN_W = ADC_BITS * 2;
  localparam int QW = 11;
  localparam logic [ADC_BITS-1:0] FULL = {ADC_BITS{1'b1}};

  localparam logic [1:0] REG_LOW = 2'd0;
  localparam logic [1:0] REG_MID = 2'd1;
  localparam logic [1:0] REG_HIGH = 2'd2;
  localparam logic [1:0] REG_SLOW = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_PER, ST_DIV2, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;      // capture sample, square reading and complement
    logic mul;       // scale numerator by 1000
    logic div_step;  // one restoring step of ppm division
    logic per_load;  // set up period division
    logic per_step;  // one step of period division
    logic finish;    // form result word, commit state
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic per_last;
    logic need_per;
  } sts_t;
endpackage

### hw/rtl/gac_ctrl.sv
// ----------------------------------------------------------------------------
// gac_ctrl
// Sequencer for one sample: multiply, ppm division, optional period division.
// ----------------------------------------------------------------------------
module gac_ctrl import gac_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  logic   out_free,
  input  sts_t   sts,
  output cmd_t   cmd,
  output logic   busy
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  if (sts.div_last) state_nxt = ST_PER;
      ST_PER:  state_nxt = sts.need_per ? ST_DIV2 : ST_DONE;
      ST_DIV2: if (sts.per_last) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: cmd.load = start;
      ST_MUL:  cmd.mul = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_PER:  cmd.per_load = 1'b1;
      ST_DIV2: cmd.per_step = 1'b1;
      ST_DONE: cmd.finish = out_free;
      default: cmd = '0;
    endcase
  end

  assign busy = (state_r != ST_IDLE);
endmodule

### hw/rtl/gac_datapath.sv
// ----------------------------------------------------------------------------
// gac_datapath
// Edge detect, ppm and period dividers, level logic, blink counters and result register.
// ----------------------------------------------------------------------------
module gac_datapath import gac_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic                tick,
  input  logic                bp,
  input  logic                bc,
  input  logic [ADC_BITS-1:0] adc,
  input  logic [9:0]          low_th,
  input  logic [9:0]          mid_th,
  input  logic [9:0]          high_th,
  input  logic [3:0]          slow_ticks,
  input  logic                out_take,
  output logic                out_valid,
  output logic [9:0]          ppm,
  output logic [1:0]          level,
  output logic                running,
  output logic                led_red,
  output logic                led_yellow,
  output logic                led_blue,
  output logic                led_green,
  output logic                buzzer_on,
  output logic                relay_on,
  output logic                alert_pulse
);
  logic active_r, pprev_r, cprev_r, alat_r;
  logic [3:0] scnt_r; logic sph_r;
  logic [4:0] fcnt_r, fper_r; logic fph_r;
  logic [ADC_BITS-1:0] a_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0] rem_r;
  logic [QW-1:0] q_r;
  logic [5:0] cnt_r;
  logic [9:0] ppmv_r;
  logic [11:0] pden_r;
  logic [13:0] pnum_r;
  logic [14:0] prem_r;
  logic [4:0] pq_r;
  logic act_n;
  logic [DEN_W:0] trial;
  logic [14:0] ptrial;
  logic [ADC_BITS-1:0] diff;
  logic [9:0] pv, d;
  logic [13:0] pden_w;

  assign act_n = cprev_r == 1'b0 && bc ? 1'b0 :
                 ((bp && !pprev_r) ? ~active_r : active_r);
  assign diff = FULL - adc;

  assign trial = {rem_r[DEN_W-1:0], num_r[NUM_W-1]} - {1'b0, den_r};
  assign ptrial = {prem_r[13:0], pnum_r[13]} - {3'b0, pden_r};
  assign sts.div_last = (cnt_r == 6'(NUM_W - 1));
  assign sts.per_last = (cnt_r == 6'd13);
  assign sts.need_per = active_r && (pv >= high_th);

  // saturated ppm, with the zero and full-scale readings as given
  always_comb begin
    if (a_r == '0) pv = 10'd0;
    else if (a_r == FULL || q_r > QW'(1000)) pv = 10'd1000;
    else pv = q_r[9:0];
  end
  assign d = pv - high_th;
  assign pden_w = 14'd400 + 14'd9 * {4'd0, d};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0; pprev_r <= 1'b0; cprev_r <= 1'b0; alat_r <= 1'b0;
      scnt_r <= '0; sph_r <= 1'b0; fcnt_r <= '0; fph_r <= 1'b0;
      fper_r <= 5'd5; out_valid <= 1'b0;
    end else begin
      if (out_take) out_valid <= 1'b0;
      if (tick) begin
        if (4'(scnt_r + 4'd1) >= slow_ticks) begin sph_r <= ~sph_r; scnt_r <= '0; end
        else scnt_r <= scnt_r + 4'd1;
        if (5'(fcnt_r + 5'd1) >= fper_r) begin fph_r <= ~fph_r; fcnt_r <= '0; end
        else fcnt_r <= fcnt_r + 5'd1;
      end
      if (cmd.load) begin
        active_r <= act_n; pprev_r <= bp; cprev_r <= bc;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (active_r) begin
          if (pv >= mid_th) alat_r <= 1'b1;
          else alat_r <= 1'b0;
          if (!(pv < low_th) && !(pv < mid_th) && !(pv < high_th))
            fper_r <= (pq_r == 5'd0) ? 5'd1 : pq_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= adc;
      num_r <= NUM_W'(DEN_W'(adc) * DEN_W'(adc));
      den_r <= DEN_W'(diff) * DEN_W'(diff);
      rem_r <= '0; q_r <= '0; cnt_r <= '0;
    end
    if (cmd.mul) num_r <= num_r * NUM_W'(1000);
    if (cmd.div_step) begin
      cnt_r <= cnt_r + 6'd1;
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      if (!trial[DEN_W] && den_r != '0) begin
        rem_r <= trial; q_r <= {q_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DEN_W-1:0], num_r[NUM_W-1]};
        // keep saturation once the quotient overflows the kept bits
        q_r <= (q_r[QW-1]) ? q_r : {q_r[QW-2:0], 1'b0};
      end
      if (!trial[DEN_W] && den_r != '0 && q_r[QW-1]) q_r <= q_r;
    end
    if (cmd.per_load) begin
      ppmv_r <= pv;
      pden_r <= (pden_w > 14'd4000) ? 12'd4000 : pden_w[11:0];
      pnum_r <= 14'd10000; prem_r <= '0; pq_r <= '0; cnt_r <= '0;
    end
    if (cmd.per_step) begin
      cnt_r <= cnt_r + 6'd1;
      pnum_r <= {pnum_r[12:0], 1'b0};
      if (!ptrial[14]) begin prem_r <= ptrial; pq_r <= {pq_r[3:0], 1'b1}; end
      else begin prem_r <= {prem_r[13:0], pnum_r[13]}; pq_r <= {pq_r[3:0], 1'b0}; end
    end
    if (cmd.finish) begin
      ppm <= active_r ? ppmv_r : 10'd0;
      running <= active_r;
      led_green <= !active_r;
      led_blue <= active_r && ppmv_r < low_th;
      led_yellow <= active_r && !(ppmv_r < low_th) && ppmv_r < mid_th;
      alert_pulse <= active_r && ppmv_r >= mid_th && !alat_r;
      if (!active_r || ppmv_r < low_th) begin
        level <= 2'd0; led_red <= 1'b0; buzzer_on <= 1'b0; relay_on <= 1'b1;
      end else if (ppmv_r < mid_th) begin
        level <= 2'd1; led_red <= 1'b0; buzzer_on <= 1'b0; relay_on <= 1'b1;
      end else if (ppmv_r < high_th) begin
        level <= 2'd2; led_red <= sph_r; buzzer_on <= 1'b0; relay_on <= 1'b1;
      end else begin
        level <= 2'd3; led_red <= fph_r; buzzer_on <= 1'b1; relay_on <= 1'b0;
      end
    end
  end
endmodule

### hw/rtl/gas_alarm_controller.sv
// ----------------------------------------------------------------------------
// gas_alarm_controller
// Alarm level, lamp, buzzer and relay control from one gas sensor reading.
// ----------------------------------------------------------------------------
// A sample word is worked in order: the accepting cycle squares the reading
// and its complement, a multiply step scales the numerator, the bit-serial
// restoring divider forms ppm, a set-up step follows and, only when the
// system is on and ppm reaches the high threshold, the period divider runs,
// then the result is handed off. One sample is worked at a time and every
// word stalls while it is in work; a tick word is taken whenever no sample
// is in work and gives no result. The result register holds until taken;
// the next word is accepted while it waits, and a finished sample then
// holds until the slot is free.
`include "gas_alarm_controller_defines.svh"
module gas_alarm_controller import gac_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic                in_button_power,
  input  logic                in_button_clear,
  input  logic [ADC_BITS-1:0] in_adc_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [9:0]          out_ppm,
  output logic [1:0]          out_level,
  output logic                out_running,
  output logic                out_led_red,
  output logic                out_led_yellow,
  output logic                out_led_blue,
  output logic                out_led_green,
  output logic                out_buzzer_on,
  output logic                out_relay_on,
  output logic                out_alert_pulse,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  logic [9:0] low_r, mid_r, high_r;
  logic [3:0] slow_r;
  logic busy, acc, start, tick, out_take, out_free;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r <= 10'd200; mid_r <= 10'd400; high_r <= 10'd600; slow_r <= 4'd5;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_LOW:  low_r <= pwdata[9:0];
        REG_MID:  mid_r <= pwdata[9:0];
        REG_HIGH: high_r <= pwdata[9:0];
        REG_SLOW: slow_r <= pwdata[3:0];
        default:  low_r <= low_r;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      REG_LOW:  prdata = {22'd0, low_r};
      REG_MID:  prdata = {22'd0, mid_r};
      REG_HIGH: prdata = {22'd0, high_r};
      REG_SLOW: prdata = {28'd0, slow_r};
      default:  prdata = '0;
    endcase
  end

  // stall while a sample is in work; a finished sample waits in the
  // sequencer for the result slot
  assign in_stall = busy;
  assign acc = in_valid && !in_stall;
  assign start = acc && !in_kind;
  assign tick = acc && in_kind;
  assign out_take = out_valid && !out_stall;
  assign out_free = !out_valid || out_take;

  gac_ctrl u_ctrl (
    .clk, .rst_n, .start, .out_free, .sts, .cmd, .busy
  );

  gac_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .tick,
    .bp(in_button_power), .bc(in_button_clear), .adc(in_adc_sample),
    .low_th(low_r), .mid_th(mid_r), .high_th(high_r), .slow_ticks(slow_r),
    .out_take, .out_valid,
    .ppm(out_ppm), .level(out_level), .running(out_running),
    .led_red(out_led_red), .led_yellow(out_led_yellow), .led_blue(out_led_blue),
    .led_green(out_led_green), .buzzer_on(out_buzzer_on),
    .relay_on(out_relay_on), .alert_pulse(out_alert_pulse)
  );

  `GAC_ASSERT_IMP(a_no_acc_busy, clk, rst_n, busy, !acc)
  `GAC_ASSERT_NXT(a_start_busy, clk, rst_n, start, busy)
  `GAC_ASSERT_IMP(a_level3_relay, clk, rst_n, out_valid && out_level == 2'd3, !out_relay_on)
  `GAC_ASSERT_IMP(a_idle_green, clk, rst_n, out_valid && !out_running, out_led_green)
endmodule

### verif/gas_alarm_controller_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gas_alarm_controller_test
// Self-checking bench for the gas alarm controller: a behavioral predictor
// tracks button edges, concentration, alarm level and blink state, and every
// result word is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module gas_alarm_controller_test;
  import gac_pkg::*;

  typedef struct packed {
    logic [9:0] ppm;
    logic [1:0] level;
    logic       running;
    logic       red;
    logic       yellow;
    logic       blue;
    logic       green;
    logic       buzzer;
    logic       relay;
    logic       alert;
  } alarm_word_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_kind, in_button_power, in_button_clear;
  logic [ADC_BITS-1:0] in_adc_sample;
  logic out_valid, out_stall;
  logic [9:0] out_ppm;
  logic [1:0] out_level;
  logic out_running, out_led_red, out_led_yellow, out_led_blue, out_led_green;
  logic out_buzzer_on, out_relay_on, out_alert_pulse;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  gas_alarm_controller u_top (.*);

  // predictor state
  logic [9:0] low_thr, mid_thr, high_thr;
  logic [3:0] slow_ticks;
  logic       active, power_prev, clear_prev, alert_latched;
  logic [3:0] slow_count;
  logic       slow_phase, fast_phase;
  logic [4:0] fast_count, fast_period;

  alarm_word_t pending_alarms[$];
  int mismatches, results_seen, idle_cycles;
  int stall_mode;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [9:0] ppm_of(logic [ADC_BITS-1:0] a);
    longint unsigned num, den, q;
    if (a == 0) return 0;
    if (a == FULL) return 1000;
    num = 1000 * longint'(a) * longint'(a);
    den = longint'(FULL - a) * longint'(FULL - a);
    q = num / den;
    return (q > 1000) ? 10'd1000 : q[9:0];
  endfunction

  // Advance predictor state for one word; queue the expected alarm word for a sample word.
  task automatic predict_word(logic kind, logic bp, logic bc, logic [ADC_BITS-1:0] adc);
    alarm_word_t w;
    int d, den, p;
    if (kind) begin
      if (5'(slow_count) + 1 >= slow_ticks) begin
        slow_phase = ~slow_phase; slow_count = 0;
      end else slow_count = slow_count + 4'd1;
      if (fast_count + 5'd1 >= fast_period) begin
        fast_phase = ~fast_phase; fast_count = 0;
      end else fast_count = fast_count + 5'd1;
      return;
    end
    if (bp && !power_prev) active = ~active;
    if (bc && !clear_prev) active = 0;
    power_prev = bp;
    clear_prev = bc;
    w = '0;
    w.relay = 1;
    w.running = active;
    if (active) begin
      w.ppm = ppm_of(adc);
      if (w.ppm >= mid_thr) begin
        if (!alert_latched) begin
          w.alert = 1; alert_latched = 1;
        end
      end else alert_latched = 0;
      if (w.ppm < low_thr) begin
        w.level = 0; w.blue = 1;
      end else if (w.ppm < mid_thr) begin
        w.level = 1; w.yellow = 1;
      end else if (w.ppm < high_thr) begin
        w.level = 2; w.red = slow_phase;
      end else begin
        d = int'(w.ppm) - int'(high_thr);
        den = 400 + 9 * d;
        if (den > 4000) den = 4000;
        p = 10000 / den;
        if (p == 0) p = 1;
        fast_period = p[4:0];
        w.level = 3; w.red = fast_phase; w.buzzer = 1; w.relay = 0;
      end
    end else w.green = 1;
    pending_alarms.push_back(w);
  endtask

  // Check each accepted alarm word against the oldest prediction.
  always @(posedge clk) begin
    alarm_word_t got, exp_w;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_ppm, out_level, out_running, out_led_red, out_led_yellow,
             out_led_blue, out_led_green, out_buzzer_on, out_relay_on,
             out_alert_pulse};
      results_seen++;
      if (pending_alarms.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected alarm word %h", got);
      end else begin
        exp_w = pending_alarms.pop_front();
        if (got !== exp_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp ppm=%0d lvl=%0d flags=%b got ppm=%0d lvl=%0d flags=%b",
                     exp_w.ppm, exp_w.level, exp_w[7:0], got.ppm, got.level, got[7:0]);
        end
      end
    end
  end

  // Receiver stall pattern; mode changes per phase.
  always @(posedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // Watchdog: cycles with nothing accepted.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("[gas_alarm_controller] ERROR");
      $finish;
    end
  end

  int burst_left;

  // Send one word; hold it until accepted. Gaps come between bursts; the
  // next send or a drain takes valid over at the accepting edge.
  task automatic send_word(logic kind, logic bp, logic bc, logic [ADC_BITS-1:0] adc);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_button_power <= bp;
    in_button_clear <= bc;
    in_adc_sample <= adc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(kind, bp, bc, adc);
  endtask

  // Wait until every prediction has come back, plus the block's latency.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_alarms.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
    case (idx)
      REG_LOW:  low_thr = val[9:0];
      REG_MID:  mid_thr = val[9:0];
      REG_HIGH: high_thr = val[9:0];
      default:  slow_ticks = val[3:0];
    endcase
  endtask

  // Turn the system on from any state with a clean power edge.
  task automatic power_on;
    send_word(0, 0, 0, 0);
    if (!active) send_word(0, 1, 0, 0);
  endtask

  task automatic test_directed;
    send_word(0, 0, 0, 12'd0);           // inactive sample
    send_word(0, 0, 0, 12'hFFF);
    send_word(0, 1, 0, 12'd0);           // power on, zero reading
    send_word(0, 1, 0, 12'hFFF);         // held button, full scale
    send_word(1, 1, 1, 12'hABC);         // tick ignores fields
    send_word(0, 0, 0, 12'd1500);
    send_word(0, 0, 0, 12'd2000);
    send_word(0, 0, 0, 12'd2300);
    send_word(0, 0, 0, 12'd2600);
    send_word(0, 0, 0, 12'd4094);
    send_word(0, 1, 1, 12'd3000);        // both edges: clear wins
    send_word(0, 0, 0, 12'd3000);
    send_word(0, 0, 1, 12'd3000);        // clear edge while inactive
    send_word(0, 1, 0, 12'd2700);
    repeat (6) send_word(1, 0, 0, 0);
    send_word(0, 0, 0, 12'd2400);
    send_word(0, 1, 0, 12'd2400);        // power toggles off
    drain;
  endtask

  task automatic random_phase(int n);
    int r;
    power_on;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) send_word(1, 1'($urandom), 1'($urandom), 12'($urandom));
      else if (r < 38) send_word(0, 1'($urandom), 1'($urandom), 12'($urandom));
      else if (r < 70) send_word(0, 0, 0, 12'($urandom_range(1800, 3000)));
      else send_word(0, 0, 0, 12'($urandom));
    end
    drain;
  endtask

  task automatic test_config_sweep;
    write_reg(REG_LOW, 0); write_reg(REG_MID, 0);
    write_reg(REG_HIGH, 0); write_reg(REG_SLOW, 0);
    stall_mode = 2;
    random_phase(250);
    write_reg(REG_LOW, 1000); write_reg(REG_MID, 1000);
    write_reg(REG_HIGH, 1000); write_reg(REG_SLOW, 15);
    stall_mode = 0;
    random_phase(250);
    write_reg(REG_LOW, 800); write_reg(REG_MID, 300);    // disordered
    write_reg(REG_HIGH, 1023); write_reg(REG_SLOW, 1);
    stall_mode = 1;
    random_phase(200);
    write_reg(REG_LOW, 200); write_reg(REG_MID, 400);
    write_reg(REG_HIGH, 600); write_reg(REG_SLOW, 5);
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_kind = 0; in_button_power = 0;
    in_button_clear = 0; in_adc_sample = 0; out_stall = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    mismatches = 0; results_seen = 0; idle_cycles = 0; burst_left = 0;
    stall_mode = 1;
    low_thr = 200; mid_thr = 400; high_thr = 600; slow_ticks = 5;
    active = 0; power_prev = 0; clear_prev = 0; alert_latched = 0;
    slow_count = 0; slow_phase = 0; fast_phase = 0; fast_count = 0;
    fast_period = 5;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed;
    stall_mode = 1;
    random_phase(500);
    test_config_sweep;
    if (pending_alarms.size() != 0) mismatches++;
    $display("Covered %0d alarm words over directed, random and threshold sweeps;",
             results_seen);
    $display("button edges, saturation, blink phases and stalls exercised.");
    if (mismatches == 0) $display("[gas_alarm_controller] OK");
    else $display("[gas_alarm_controller] ERROR");
    $finish;
  end
endmodule
